/* rtl/hssf_pkg.sv */
// Shared constants for the haptic sphere spring force block.
// Register indexes, fixed field widths and divider sizing; no dependencies.
package hssf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int RAD_W      = 19;
    localparam int GAIN_W     = 16;
    localparam int FMAX_W     = 15;
    // clamp limit is force_max scaled by 1024
    localparam int LIM_SHIFT  = 10;
    // quotient bits of each force component before saturation
    localparam int QW         = 18;

    localparam logic [CFG_IDX_W-1:0] REG_SPHERE_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPHERE_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPHERE_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPHERE_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_RADIUS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPRING_GAIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_MAX     = 3'd6;

    localparam logic [RAD_W-1:0]  RST_SPHERE_RADIUS = 19'd10240;
    localparam logic [RAD_W-1:0]  RST_CURSOR_RADIUS = 19'd2048;
    localparam logic [GAIN_W-1:0] RST_SPRING_GAIN   = 16'hC400;
    localparam logic [FMAX_W-1:0] RST_FORCE_MAX     = 15'd15360;

endpackage

/* rtl/haptic_sphere_spring_force.sv */
// One word accepted per cycle while in_stall is low; depth is set by the
// bit-per-stage square root and the bit-per-stage divider (QW stages, three lanes).
// An output skid register holds one word when the sink stalls.
// Reset: asynchronous, active low; clears valid bits, inside flag and restores
// the configuration registers to their defaults.
module haptic_sphere_spring_force
    import hssf_pkg::*;
#(
    parameter int POS_WIDTH   = 20,
    parameter int FORCE_WIDTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [(POS_WIDTH > RAD_W ? POS_WIDTH : RAD_W)-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [POS_WIDTH-1:0]   pos_x,
    input  logic signed [POS_WIDTH-1:0]   pos_y,
    input  logic signed [POS_WIDTH-1:0]   pos_z,
    input  logic                          just_activated,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [FORCE_WIDTH-1:0] force_x,
    output logic signed [FORCE_WIDTH-1:0] force_y,
    output logic signed [FORCE_WIDTH-1:0] force_z,
    output logic                          inside_mode,
    output logic                          in_contact,
    output logic                          clamped
);

    localparam int NS    = (POS_WIDTH > 31) ? 1 : 0;
    localparam int DFW   = POS_WIDTH + 1;
    localparam int ADW   = POS_WIDTH + 1;
    localparam int AW    = ADW - NS;
    localparam int SQW   = 2 * AW;
    localparam int SUMW  = SQW + 2;
    localparam int RTW   = SUMW / 2;
    localparam int TW    = SUMW + 2;
    localparam int DW    = RTW + NS;
    localparam int EW    = ((DW > RAD_W + 1) ? DW : RAD_W + 1) + 2;
    localparam int SW    = GAIN_W + EW;
    localparam int MW    = FMAX_W + LIM_SHIFT;
    localparam int NUMW  = MW + ADW;
    localparam int DENW  = DW + LIM_SHIFT;
    localparam int D2W   = DENW + 1;
    localparam int NW    = ((NUMW + 1 > DENW) ? NUMW + 1 : DENW) + 1;
    localparam int CW    = ((NW > D2W) ? NW : D2W) + QW;
    localparam int XW    = (QW > FORCE_WIDTH) ? QW : FORCE_WIDTH;
    localparam logic [XW-1:0] FMAXV = XW'((64'd1 << (FORCE_WIDTH - 1)) - 64'd1);

    typedef struct packed {
        logic [ADW-1:0] ad_x;
        logic [ADW-1:0] ad_y;
        logic [ADW-1:0] ad_z;
        logic           neg_x;
        logic           neg_y;
        logic           neg_z;
    } geo_t;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
        logic contact;
        logic clamp;
        logic flag;
    } tag_t;

    // configuration
    logic [POS_WIDTH-1:0] sphere_x_reg, sphere_y_reg, sphere_z_reg;
    logic [RAD_W-1:0]     sphere_radius_reg, cursor_radius_reg;
    logic [GAIN_W-1:0]    spring_gain_reg;
    logic [FMAX_W-1:0]    force_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sphere_x_reg      <= '0;
            sphere_y_reg      <= '0;
            sphere_z_reg      <= POS_WIDTH'(-64'sd10240);
            sphere_radius_reg <= RST_SPHERE_RADIUS;
            cursor_radius_reg <= RST_CURSOR_RADIUS;
            spring_gain_reg   <= RST_SPRING_GAIN;
            force_max_reg     <= RST_FORCE_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPHERE_X:      sphere_x_reg      <= cfg_data[POS_WIDTH-1:0];
                REG_SPHERE_Y:      sphere_y_reg      <= cfg_data[POS_WIDTH-1:0];
                REG_SPHERE_Z:      sphere_z_reg      <= cfg_data[POS_WIDTH-1:0];
                REG_SPHERE_RADIUS: sphere_radius_reg <= cfg_data[RAD_W-1:0];
                REG_CURSOR_RADIUS: cursor_radius_reg <= cfg_data[RAD_W-1:0];
                REG_SPRING_GAIN:   spring_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_FORCE_MAX:     force_max_reg     <= cfg_data[FMAX_W-1:0];
                default:           ;
            endcase
        end
    end

    // pipeline advances as a whole; the skid register absorbs one stalled word
    logic skid_valid_reg, skid_valid_next;
    logic en;
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // stage 1: offsets and magnitudes
    logic               s1_v_reg;
    geo_t               s1_geo_reg;
    logic               s1_act_reg;
    logic signed [DFW-1:0] dx, dy, dz;
    geo_t               s1_geo_next;

    always_comb
    begin
        dx = DFW'(pos_x) - DFW'($signed(sphere_x_reg));
        dy = DFW'(pos_y) - DFW'($signed(sphere_y_reg));
        dz = DFW'(pos_z) - DFW'($signed(sphere_z_reg));
        s1_geo_next.neg_x = dx[DFW-1];
        s1_geo_next.neg_y = dy[DFW-1];
        s1_geo_next.neg_z = dz[DFW-1];
        s1_geo_next.ad_x  = dx[DFW-1] ? ADW'(-dx) : ADW'(dx);
        s1_geo_next.ad_y  = dy[DFW-1] ? ADW'(-dy) : ADW'(dy);
        s1_geo_next.ad_z  = dz[DFW-1] ? ADW'(-dz) : ADW'(dz);
    end

    // stage 2: squares
    logic            s2_v_reg;
    geo_t            s2_geo_reg;
    logic            s2_act_reg;
    logic [SQW-1:0]  s2_sqx_reg, s2_sqy_reg, s2_sqz_reg;
    logic [AW-1:0]   hx, hy, hz;
    assign hx = s1_geo_reg.ad_x[ADW-1:NS];
    assign hy = s1_geo_reg.ad_y[ADW-1:NS];
    assign hz = s1_geo_reg.ad_z[ADW-1:NS];

    // stage 3: sum of squares
    logic            s3_v_reg;
    geo_t            s3_geo_reg;
    logic            s3_act_reg;
    logic [SUMW-1:0] s3_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_geo_reg <= s1_geo_next;
            s1_act_reg <= just_activated;
            s2_geo_reg <= s1_geo_reg;
            s2_act_reg <= s1_act_reg;
            s2_sqx_reg <= hx * hx;
            s2_sqy_reg <= hy * hy;
            s2_sqz_reg <= hz * hz;
            s3_geo_reg <= s2_geo_reg;
            s3_act_reg <= s2_act_reg;
            s3_sum_reg <= SUMW'(s2_sqx_reg) + SUMW'(s2_sqy_reg) + SUMW'(s2_sqz_reg);
        end
    end

    // square root, one result bit per stage, top bit first
    logic            rt_v_reg    [RTW];
    geo_t            rt_geo_reg  [RTW];
    logic            rt_act_reg  [RTW];
    logic [SUMW-1:0] rt_rem_reg  [RTW];
    logic [RTW-1:0]  rt_root_reg [RTW];

    genvar k;
    generate
        for (k = 0; k < RTW; k++)
        begin : g_root
            localparam int B = RTW - 1 - k;
            logic            v_in;
            geo_t            geo_in;
            logic            act_in;
            logic [SUMW-1:0] rem_in;
            logic [RTW-1:0]  root_in;
            logic [TW-1:0]   trial;
            logic            take;

            if (k == 0)
            begin : g_first
                assign v_in    = s3_v_reg;
                assign geo_in  = s3_geo_reg;
                assign act_in  = s3_act_reg;
                assign rem_in  = s3_sum_reg;
                assign root_in = '0;
            end
            else
            begin : g_next
                assign v_in    = rt_v_reg[k-1];
                assign geo_in  = rt_geo_reg[k-1];
                assign act_in  = rt_act_reg[k-1];
                assign rem_in  = rt_rem_reg[k-1];
                assign root_in = rt_root_reg[k-1];
            end

            // root is a multiple of 2^(B+1), so the OR is an add
            assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));
            assign take  = TW'(rem_in) >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    rt_v_reg[k] <= 1'b0;
                else if (en)
                    rt_v_reg[k] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rt_geo_reg[k]  <= geo_in;
                    rt_act_reg[k]  <= act_in;
                    rt_rem_reg[k]  <= take ? rem_in - trial[SUMW-1:0] : rem_in;
                    rt_root_reg[k] <= root_in | (take ? (RTW'(1) << B) : '0);
                end
            end
        end
    endgenerate

    // stage E: distance, mode latch, penetration
    logic                 inside_flag_reg;
    logic [DW-1:0]        d_cur;
    logic                 flag_cur;
    logic signed [EW-1:0] e_cur;
    logic                 pen_cur;
    logic signed [EW-1:0] d_s, r_s, c_s;

    always_comb
    begin
        d_cur    = DW'(rt_root_reg[RTW-1]) << NS;
        d_s      = $signed(EW'(d_cur));
        r_s      = $signed(EW'(sphere_radius_reg));
        c_s      = $signed(EW'(cursor_radius_reg));
        flag_cur = rt_act_reg[RTW-1] ? (d_s < r_s) : inside_flag_reg;
        if (flag_cur)
        begin
            e_cur   = d_s - (r_s - c_s);
            pen_cur = e_cur > 0;
        end
        else
        begin
            e_cur   = d_s - (r_s + c_s);
            pen_cur = e_cur < 0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inside_flag_reg <= 1'b0;
        else if (en && rt_v_reg[RTW-1])
            inside_flag_reg <= flag_cur;
    end

    logic                 se_v_reg;
    geo_t                 se_geo_reg;
    logic [DW-1:0]        se_d_reg;
    logic                 se_flag_reg, se_pen_reg;
    logic signed [EW-1:0] se_e_reg;

    // stage M: spring term
    logic                 sm_v_reg;
    geo_t                 sm_geo_reg;
    logic [DW-1:0]        sm_d_reg;
    logic                 sm_flag_reg, sm_pen_reg;
    logic signed [SW-1:0] sm_s_reg;

    // stage C: clamp
    logic                 sc_v_reg;
    geo_t                 sc_geo_reg;
    logic [DW-1:0]        sc_d_reg;
    logic                 sc_flag_reg, sc_contact_reg, sc_clamp_reg, sc_sneg_reg;
    logic [MW-1:0]        sc_mag_reg;
    logic [SW-1:0]        abs_s;
    logic [MW-1:0]        lim;
    logic                 contact_cur, clamp_cur;

    always_comb
    begin
        abs_s       = sm_s_reg[SW-1] ? SW'(-sm_s_reg) : SW'(sm_s_reg);
        lim         = {force_max_reg, LIM_SHIFT'(0)};
        contact_cur = sm_pen_reg && (sm_s_reg != '0);
        clamp_cur   = contact_cur && (abs_s > SW'(lim));
    end

    // stage P: numerators
    logic                 sp_v_reg;
    tag_t                 sp_tag_reg;
    logic [DW-1:0]        sp_d_reg;
    logic [NUMW-1:0]      sp_nx_reg, sp_ny_reg, sp_nz_reg;

    // stage N: rounded dividends and divisor
    logic                 sn_v_reg;
    tag_t                 sn_tag_reg;
    logic [D2W-1:0]       sn_div_reg;
    logic [NW-1:0]        sn_num_reg [3];
    logic [NW-1:0]        den_ext;
    assign den_ext = NW'({sp_d_reg, LIM_SHIFT'(0)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            se_v_reg <= 1'b0;
            sm_v_reg <= 1'b0;
            sc_v_reg <= 1'b0;
            sp_v_reg <= 1'b0;
            sn_v_reg <= 1'b0;
        end
        else if (en)
        begin
            se_v_reg <= rt_v_reg[RTW-1];
            sm_v_reg <= se_v_reg;
            sc_v_reg <= sm_v_reg;
            sp_v_reg <= sc_v_reg;
            sn_v_reg <= sp_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            se_geo_reg  <= rt_geo_reg[RTW-1];
            se_d_reg    <= d_cur;
            se_flag_reg <= flag_cur;
            // zero distance has no direction: no force
            se_pen_reg  <= pen_cur && (d_cur != '0);
            se_e_reg    <= e_cur;

            sm_geo_reg  <= se_geo_reg;
            sm_d_reg    <= se_d_reg;
            sm_flag_reg <= se_flag_reg;
            sm_pen_reg  <= se_pen_reg;
            sm_s_reg    <= SW'($signed(spring_gain_reg)) * SW'(se_e_reg);

            sc_geo_reg     <= sm_geo_reg;
            sc_d_reg       <= sm_d_reg;
            sc_flag_reg    <= sm_flag_reg;
            sc_contact_reg <= contact_cur;
            sc_clamp_reg   <= clamp_cur;
            sc_sneg_reg    <= sm_s_reg[SW-1];
            sc_mag_reg     <= clamp_cur ? lim : abs_s[MW-1:0];

            sp_tag_reg.neg_x   <= sc_geo_reg.neg_x ^ sc_sneg_reg;
            sp_tag_reg.neg_y   <= sc_geo_reg.neg_y ^ sc_sneg_reg;
            sp_tag_reg.neg_z   <= sc_geo_reg.neg_z ^ sc_sneg_reg;
            sp_tag_reg.contact <= sc_contact_reg;
            sp_tag_reg.clamp   <= sc_clamp_reg;
            sp_tag_reg.flag    <= sc_flag_reg;
            sp_d_reg           <= sc_d_reg;
            sp_nx_reg          <= NUMW'(sc_mag_reg) * NUMW'(sc_geo_reg.ad_x);
            sp_ny_reg          <= NUMW'(sc_mag_reg) * NUMW'(sc_geo_reg.ad_y);
            sp_nz_reg          <= NUMW'(sc_mag_reg) * NUMW'(sc_geo_reg.ad_z);

            sn_tag_reg    <= sp_tag_reg;
            sn_div_reg    <= {sp_d_reg, (LIM_SHIFT + 1)'(0)};
            sn_num_reg[0] <= (NW'(sp_nx_reg) << 1) + den_ext;
            sn_num_reg[1] <= (NW'(sp_ny_reg) << 1) + den_ext;
            sn_num_reg[2] <= (NW'(sp_nz_reg) << 1) + den_ext;
        end
    end

    // restoring divider, one quotient bit per stage, three lanes
    logic           dv_v_reg   [QW];
    tag_t           dv_tag_reg [QW];
    logic [D2W-1:0] dv_div_reg [QW];
    logic [NW-1:0]  dv_rem_reg [QW][3];
    logic [QW-1:0]  dv_q_reg   [QW][3];

    genvar j, l;
    generate
        for (j = 0; j < QW; j++)
        begin : g_div
            localparam int J = QW - 1 - j;
            logic           v_in;
            tag_t           tag_in;
            logic [D2W-1:0] div_in;
            logic [CW-1:0]  sh;

            if (j == 0)
            begin : g_first
                assign v_in   = sn_v_reg;
                assign tag_in = sn_tag_reg;
                assign div_in = sn_div_reg;
            end
            else
            begin : g_next
                assign v_in   = dv_v_reg[j-1];
                assign tag_in = dv_tag_reg[j-1];
                assign div_in = dv_div_reg[j-1];
            end

            assign sh = CW'(div_in) << J;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_v_reg[j] <= 1'b0;
                else if (en)
                    dv_v_reg[j] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_tag_reg[j] <= tag_in;
                    dv_div_reg[j] <= div_in;
                end
            end

            for (l = 0; l < 3; l++)
            begin : g_lane
                logic [NW-1:0] rem_in;
                logic [QW-1:0] q_in;
                logic          take;

                if (j == 0)
                begin : g_first
                    assign rem_in = sn_num_reg[l];
                    assign q_in   = '0;
                end
                else
                begin : g_next
                    assign rem_in = dv_rem_reg[j-1][l];
                    assign q_in   = dv_q_reg[j-1][l];
                end

                assign take = CW'(rem_in) >= sh;

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        dv_rem_reg[j][l] <= take ? rem_in - sh[NW-1:0] : rem_in;
                        dv_q_reg[j][l]   <= q_in | (take ? (QW'(1) << J) : '0);
                    end
                end
            end
        end
    endgenerate

    // output stage: saturate, apply sign, zero force without contact
    logic                   o_v_reg;
    logic [FORCE_WIDTH-1:0] o_f_reg [3];
    logic                   o_flag_reg, o_contact_reg, o_clamp_reg;
    logic [FORCE_WIDTH-1:0] f_cur [3];
    logic [2:0]             neg_vec;
    assign neg_vec = {dv_tag_reg[QW-1].neg_z, dv_tag_reg[QW-1].neg_y,
                      dv_tag_reg[QW-1].neg_x};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [XW-1:0] qe;
            qe = XW'(dv_q_reg[QW-1][i]);
            if (qe > FMAXV)
                qe = FMAXV;
            if (!dv_tag_reg[QW-1].contact)
                f_cur[i] = '0;
            else if (neg_vec[i])
                f_cur[i] = FORCE_WIDTH'(-qe);
            else
                f_cur[i] = FORCE_WIDTH'(qe);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_v_reg <= 1'b0;
        else if (en)
            o_v_reg <= dv_v_reg[QW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_f_reg       <= f_cur;
            o_flag_reg    <= dv_tag_reg[QW-1].flag;
            o_contact_reg <= dv_tag_reg[QW-1].contact;
            o_clamp_reg   <= dv_tag_reg[QW-1].clamp;
        end
    end

    // skid register
    logic [FORCE_WIDTH-1:0] sk_f_reg [3];
    logic                   sk_flag_reg, sk_contact_reg, sk_clamp_reg;
    logic                   sk_load;

    always_comb
    begin
        sk_load         = 1'b0;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (!out_stall)
                skid_valid_next = 1'b0;
        end
        else if (o_v_reg && out_stall)
        begin
            sk_load         = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else
            skid_valid_reg <= skid_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (sk_load)
        begin
            sk_f_reg       <= o_f_reg;
            sk_flag_reg    <= o_flag_reg;
            sk_contact_reg <= o_contact_reg;
            sk_clamp_reg   <= o_clamp_reg;
        end
    end

    assign out_valid   = skid_valid_reg || o_v_reg;
    assign force_x     = $signed(skid_valid_reg ? sk_f_reg[0] : o_f_reg[0]);
    assign force_y     = $signed(skid_valid_reg ? sk_f_reg[1] : o_f_reg[1]);
    assign force_z     = $signed(skid_valid_reg ? sk_f_reg[2] : o_f_reg[2]);
    assign inside_mode = skid_valid_reg ? sk_flag_reg : o_flag_reg;
    assign in_contact  = skid_valid_reg ? sk_contact_reg : o_contact_reg;
    assign clamped     = skid_valid_reg ? sk_clamp_reg : o_clamp_reg;

`ifndef SYNTHESIS
    a_no_force_without_contact: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_contact |-> force_x == 0 && force_y == 0 && force_z == 0)
        else $error("force present without contact");

    a_clamp_needs_contact: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clamped |-> in_contact)
        else $error("clamped without contact");

    a_stalled_word_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && !skid_valid_reg |=> skid_valid_reg)
        else $error("stalled word not held in skid register");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_stall |=> !skid_valid_reg)
        else $error("skid register did not drain");
`endif

endmodule
